FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

// check a property outside reset
`define ASSERT_RUN(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/dmxp_pkg.sv
package dmxp_pkg;

  localparam int CHANNEL_COUNT = 512;
  localparam int HEADER_BYTES  = 7;

  localparam int CH_W  = $clog2(CHANNEL_COUNT);
  localparam int OFF_W = 10;
  localparam int REL_W = 4;

  localparam logic [OFF_W-1:0] FIELD_START  = OFF_W'(HEADER_BYTES + 1);
  localparam logic [OFF_W-1:0] DATA_START   = OFF_W'(HEADER_BYTES + 11);
  localparam logic [OFF_W-1:0] PACKET_TOTAL = OFF_W'(HEADER_BYTES + 11 + CHANNEL_COUNT);
  localparam logic [OFF_W-1:0] LAST_OFFSET  = OFF_W'(HEADER_BYTES + 10 + CHANNEL_COUNT);

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [0:0] CFG_SCALE_MIN = 1'd0;
  localparam logic [0:0] CFG_SCALE_MAX = 1'd1;

  localparam logic [REL_W-1:0] REL_OPCODE_LO   = 4'd0;
  localparam logic [REL_W-1:0] REL_OPCODE_HI   = 4'd1;
  localparam logic [REL_W-1:0] REL_VERSION_LO  = 4'd2;
  localparam logic [REL_W-1:0] REL_VERSION_HI  = 4'd3;
  localparam logic [REL_W-1:0] REL_SEQUENCE    = 4'd4;
  localparam logic [REL_W-1:0] REL_PHYSICAL    = 4'd5;
  localparam logic [REL_W-1:0] REL_UNIVERSE_LO = 4'd6;
  localparam logic [REL_W-1:0] REL_UNIVERSE_HI = 4'd7;
  localparam logic [REL_W-1:0] REL_LENGTH_LO   = 4'd8;
  localparam logic [REL_W-1:0] REL_LENGTH_HI   = 4'd9;

  typedef struct packed {
    logic            wr;
    logic [CH_W-1:0] addr;
    logic            field_en;
    logic [REL_W-1:0] rel;
    logic            done;
    logic            blank;
  } seq_info_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    seq_info_t   info;
    logic        fwd;
  } stage_t;

endpackage

FILE: rtl/dmx_packet_field_parser.sv
// An accepted request is registered in s1_r and then in out_data_r on its way to
// out_tvalid. Throughput: one request per cycle while in_tready is high; the channel
// store reads at accept and writes back as the request leaves s1_r, with forwarding
// between neighboring requests. Reset (rst_n low, synchronous) clears all control
// state, then a pass zeroes the channel store with in_tready held low; cfg writes stay open.
module dmx_packet_field_parser
  import dmxp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // byte_value[7:0], channel_index[16:8], zero fill
  input  logic [2:0]   in_tuser,   // kind[1:0], start_of_packet[2]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // opcode_field[15:0], version_field[31:16],
                                   // sequence_field[39:32], physical_field[47:40],
                                   // universe_field[63:48], length_field[79:64],
                                   // channel_value[87:80], scaled_value[103:88]
  output logic         out_tlast,  // packet_done
  output logic [0:0]   out_tuser,  // changed
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [1:0]      in_kind;
  logic [7:0]      in_byte;
  logic            in_sop;
  logic [CH_W-1:0] in_index;
  logic            accept;
  logic            s1_fire;
  logic            ram_busy;
  logic            rd_en;
  logic [CH_W-1:0] rd_addr;
  logic [7:0]      rd_data;
  seq_info_t       info;

  logic            s1_valid_r;
  stage_t          s1_r;
  logic [7:0]      fwd_data_r;

  logic [15:0] scale_min_r;
  logic [15:0] scale_max_r;
  logic        changed_r;
  logic        changed_nxt;
  logic [15:0] opcode_r;
  logic [15:0] opcode_nxt;
  logic [15:0] version_r;
  logic [15:0] version_nxt;
  logic [7:0]  sequence_r;
  logic [7:0]  sequence_nxt;
  logic [7:0]  physical_r;
  logic [7:0]  physical_nxt;
  logic [15:0] universe_r;
  logic [15:0] universe_nxt;
  logic [15:0] length_r;
  logic [15:0] length_nxt;

  logic [7:0]  stored;
  logic [7:0]  chval;
  logic [15:0] range;
  logic [23:0] product;
  logic [15:0] scaled;

  logic         out_valid_r;
  logic [103:0] out_data_r;
  logic         out_last_r;
  logic         out_changed_r;

  assign in_kind  = in_tuser[1:0];
  assign in_sop   = in_tuser[2];
  assign in_byte  = in_tdata[7:0];
  assign in_index = in_tdata[16:8];

  assign s1_fire   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~ram_busy & (~s1_valid_r | s1_fire);
  assign accept    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  dmxp_sequencer u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .kind            (in_kind),
    .byte_value      (in_byte),
    .start_of_packet (in_sop),
    .info            (info)
  );

  assign rd_addr = (in_kind == KIND_READ) ? in_index : info.addr;
  assign rd_en   = accept & ((in_kind == KIND_READ) | info.wr);

  dmxp_chan_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s1_fire & s1_r.info.wr),
    .wr_addr (s1_r.info.addr),
    .wr_data (s1_r.byte_value),
    .busy    (ram_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.kind       <= in_kind;
      s1_r.byte_value <= in_byte;
      s1_r.info       <= info;
      s1_r.fwd        <= s1_fire & s1_r.info.wr & (s1_r.info.addr == rd_addr);
      fwd_data_r      <= s1_r.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_min_r <= 16'd0;
      scale_max_r <= 16'hFFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE_MIN: scale_min_r <= cfg_data;
        CFG_SCALE_MAX: scale_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    stored       = s1_r.fwd ? fwd_data_r : rd_data;
    changed_nxt  = changed_r;
    opcode_nxt   = opcode_r;
    version_nxt  = version_r;
    sequence_nxt = sequence_r;
    physical_nxt = physical_r;
    universe_nxt = universe_r;
    length_nxt   = length_r;
    if (s1_r.kind == KIND_CLEAR) begin
      changed_nxt = 1'b0;
    end else if (s1_r.info.wr) begin
      changed_nxt = changed_r | (stored != s1_r.byte_value) | s1_r.info.blank;
    end
    if (s1_r.info.field_en) begin
      case (s1_r.info.rel)
        REL_OPCODE_LO:   opcode_nxt[7:0]    = s1_r.byte_value;
        REL_OPCODE_HI:   opcode_nxt[15:8]   = s1_r.byte_value;
        REL_VERSION_LO:  version_nxt[7:0]   = s1_r.byte_value;
        REL_VERSION_HI:  version_nxt[15:8]  = s1_r.byte_value;
        REL_SEQUENCE:    sequence_nxt       = s1_r.byte_value;
        REL_PHYSICAL:    physical_nxt       = s1_r.byte_value;
        REL_UNIVERSE_LO: universe_nxt[7:0]  = s1_r.byte_value;
        REL_UNIVERSE_HI: universe_nxt[15:8] = s1_r.byte_value;
        REL_LENGTH_LO:   length_nxt[7:0]    = s1_r.byte_value;
        REL_LENGTH_HI:   length_nxt[15:8]   = s1_r.byte_value;
        default: ;
      endcase
    end
    range   = scale_max_r - scale_min_r;
    product = 24'(stored) * 24'(range);
    chval   = 8'd0;
    scaled  = 16'd0;
    if (s1_r.kind == KIND_READ) begin
      chval  = stored;
      scaled = (scale_max_r < scale_min_r) ? scale_min_r : scale_min_r + product[23:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r  <= 1'b0;
      opcode_r   <= 16'd0;
      version_r  <= 16'd0;
      sequence_r <= 8'd0;
      physical_r <= 8'd0;
      universe_r <= 16'd0;
      length_r   <= 16'd0;
    end else if (s1_fire) begin
      changed_r  <= changed_nxt;
      opcode_r   <= opcode_nxt;
      version_r  <= version_nxt;
      sequence_r <= sequence_nxt;
      physical_r <= physical_nxt;
      universe_r <= universe_nxt;
      length_r   <= length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r    <= {scaled, chval, length_nxt, universe_nxt, physical_nxt,
                        sequence_nxt, version_nxt, opcode_nxt};
      out_last_r    <= s1_r.info.done;
      out_changed_r <= changed_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_changed_r;

endmodule

FILE: rtl/dmxp_chan_ram.sv
module dmxp_chan_ram
  import dmxp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_addr,
  output logic [7:0]      rd_data,
  input  logic            wr_en,
  input  logic [CH_W-1:0] wr_addr,
  input  logic [7:0]      wr_data,
  output logic            busy
);

  logic [7:0]    mem [CHANNEL_COUNT];
  logic [7:0]    rd_data_r;
  logic [CH_W:0] clr_cnt_r;
  logic [CH_W:0] clr_cnt_nxt;
  logic          clearing_r;
  logic          clearing_nxt;
  logic          mem_we;
  logic [CH_W-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == (CH_W+1)'(CHANNEL_COUNT - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    mem_we    = clearing_r | wr_en;
    mem_waddr = clearing_r ? clr_cnt_r[CH_W-1:0] : wr_addr;
    mem_wdata = clearing_r ? 8'd0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

FILE: rtl/dmxp_sequencer.sv
module dmxp_sequencer
  import dmxp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] kind,
  input  logic [7:0] byte_value,
  input  logic       start_of_packet,
  output seq_info_t  info
);

  logic [OFF_W-1:0] off_r;
  logic [OFF_W-1:0] off_nxt;
  logic             az_r;
  logic             az_nxt;
  logic [OFF_W-1:0] off;
  logic             az;
  logic [OFF_W-1:0] ch_off;
  logic [OFF_W-1:0] rel_off;

  always_comb begin
    off     = start_of_packet ? '0 : off_r;
    az      = start_of_packet ? 1'b1 : az_r;
    ch_off  = off - DATA_START;
    rel_off = off - FIELD_START;
    info    = '0;
    off_nxt = off_r;
    az_nxt  = az_r;
    info.addr = ch_off[CH_W-1:0];
    info.rel  = rel_off[REL_W-1:0];
    if (kind == KIND_BYTE) begin
      off_nxt = off;
      az_nxt  = az;
      if (off < PACKET_TOTAL) begin
        off_nxt = off + 1'b1;
        if (off >= DATA_START) begin
          info.wr    = 1'b1;
          az_nxt     = az & (byte_value == 8'd0);
          info.done  = (off == LAST_OFFSET);
          info.blank = (off == LAST_OFFSET) & az & (byte_value == 8'd0);
        end else if (off >= FIELD_START) begin
          info.field_en = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= PACKET_TOTAL;
      az_r  <= 1'b1;
    end else if (accept) begin
      off_r <= off_nxt;
      az_r  <= az_nxt;
    end
  end

endmodule

FILE: rtl/dmxp_checker.sv
`include "assert_macros.svh"

module dmxp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tlast
);

  `ASSERT_ALWAYS(a_ready_low_after_reset, clk, !rst_n |=> !in_tready)
  `ASSERT_ALWAYS(a_no_result_after_reset, clk, !rst_n |=> !out_tvalid)
  `ASSERT_RUN(a_stall_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `ASSERT_RUN(a_done_has_no_read, clk, rst_n, out_tvalid && out_tlast |-> out_tdata[103:80] == 24'd0)

endmodule

bind dmx_packet_field_parser dmxp_checker u_dmxp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
